FILE: rtl/core/char_lcd_bus_sequencer_macros.svh
// Assertion macros used by the sequencer back end.
`ifndef CHAR_LCD_BUS_SEQUENCER_MACROS_SVH
`define CHAR_LCD_BUS_SEQUENCER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CLBS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define CLBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/clbs_pkg.sv
// Types, constants and tables of the character LCD bus sequencer.
package clbs_pkg;

  localparam int LINE_LENGTH = 40;
  localparam int QUEUE_DEPTH = 4;

  localparam int CFG_INDEX_W = 2;
  localparam int HOLD_W      = 15;

  localparam logic [CFG_INDEX_W-1:0] REG_FOUR_BIT_BUS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_UPPER_LANE   = 2'd1;

  localparam logic [HOLD_W-1:0] HOLD_STROBE  = 15'd1;
  localparam logic [HOLD_W-1:0] HOLD_NIBBLE  = 15'd100;
  localparam logic [HOLD_W-1:0] HOLD_CMD     = 15'd10000;
  localparam logic [HOLD_W-1:0] HOLD_DATA    = 15'd100;
  localparam logic [HOLD_W-1:0] HOLD_CLEAR   = 15'd12000;
  localparam logic [HOLD_W-1:0] HOLD_POWERUP = 15'd20000;

  localparam logic [7:0] ROW1_BASE = 8'h80;
  localparam logic [7:0] ROW2_BASE = 8'hC0;

  typedef enum logic [1:0] {
    KIND_COMMAND = 2'd0,
    KIND_DATA    = 2'd1,
    KIND_INIT    = 2'd2,
    KIND_CURSOR  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] byte_value;
    logic [1:0] cursor_row;
    logic [5:0] cursor_column;
  } request_t;

  typedef struct packed {
    logic [7:0]        bus_pins;
    logic              register_select;
    logic              enable_pin;
    logic [HOLD_W-1:0] hold_us;
    logic              last_state;
  } pin_state_t;

  typedef enum logic {
    OP_POWERUP = 1'b0,
    OP_BYTE    = 1'b1
  } op_kind_t;

  typedef enum logic [1:0] {
    TAIL_CMD   = 2'd0,
    TAIL_DATA  = 2'd1,
    TAIL_CLEAR = 2'd2
  } tail_t;

  // One queued transfer: a power-up wait or one byte on the bus.
  typedef struct packed {
    op_kind_t   op_kind;
    logic [7:0] byte_value;
    logic       register_select;
    tail_t      tail;
    logic       last;
  } op_t;

  typedef struct packed {
    logic four_bit_bus;
    logic upper_nibble_lane;
  } cfg_t;

  function automatic logic [HOLD_W-1:0] tail_hold(tail_t tail);
    logic [HOLD_W-1:0] hold;
    unique case (tail)
      TAIL_DATA:  hold = HOLD_DATA;
      TAIL_CLEAR: hold = HOLD_CLEAR;
      default:    hold = HOLD_CMD;
    endcase
    return hold;
  endfunction

  // Command bytes of the init sequence, step 1 onward.
  function automatic logic [7:0] init_byte(logic [2:0] step, logic four);
    logic [7:0] b;
    if (four) begin
      unique case (step)
        3'd1:    b = 8'h33;
        3'd2:    b = 8'h32;
        3'd3:    b = 8'h28;
        3'd4:    b = 8'h0E;
        3'd5:    b = 8'h01;
        default: b = 8'h06;
      endcase
    end else begin
      unique case (step)
        3'd1:    b = 8'h38;
        3'd2:    b = 8'h0E;
        3'd3:    b = 8'h01;
        default: b = 8'h06;
      endcase
    end
    return b;
  endfunction

  function automatic logic [2:0] init_last_step(logic four);
    return four ? 3'd6 : 3'd4;
  endfunction

  function automatic logic [7:0] place_nibble(logic [3:0] nib, logic upper);
    return upper ? {nib, 4'h0} : {4'h0, nib};
  endfunction

endpackage

FILE: rtl/core/clbs_front.sv
// Front end: accepts requests and turns them into queued bus transfers.
module clbs_front #(
  parameter int LINE_LENGTH = clbs_pkg::LINE_LENGTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  clbs_pkg::request_t request,
  input  clbs_pkg::cfg_t    cfg,
  input  logic              q_full,
  output logic              q_push,
  output clbs_pkg::op_t     q_op
);

  localparam logic [5:0] COL_MAX = 6'(LINE_LENGTH);

  logic       busy, busy_next;
  logic [2:0] step, step_next;
  logic [5:0] col_sat;
  logic [7:0] cursor_byte;
  logic [7:0] step_byte;

  always_comb begin
    if (request.cursor_column == 6'd0) begin
      col_sat = 6'd1;
    end else if (request.cursor_column > COL_MAX) begin
      col_sat = COL_MAX;
    end else begin
      col_sat = request.cursor_column;
    end
    cursor_byte = ((request.cursor_row >= 2'd2) ? clbs_pkg::ROW2_BASE : clbs_pkg::ROW1_BASE)
                  + {2'b00, col_sat} - 8'd1;
    step_byte = clbs_pkg::init_byte(step, cfg.four_bit_bus);
  end

  assign full = busy | q_full;

  always_comb begin
    busy_next = busy;
    step_next = step;
    q_push    = 1'b0;
    q_op      = '{op_kind: clbs_pkg::OP_BYTE, byte_value: request.byte_value,
                  register_select: 1'b0, tail: clbs_pkg::TAIL_CMD, last: 1'b1};
    if (busy) begin
      // walk the init command list, one transfer per free queue slot
      q_op.byte_value = step_byte;
      q_op.last       = (step == clbs_pkg::init_last_step(cfg.four_bit_bus));
      if (step_byte == 8'h01) begin
        q_op.tail = clbs_pkg::TAIL_CLEAR;
      end
      if (!q_full) begin
        q_push = 1'b1;
        if (q_op.last) begin
          busy_next = 1'b0;
        end else begin
          step_next = step + 3'd1;
        end
      end
    end else begin
      q_push = push && !q_full;
      unique case (request.kind)
        clbs_pkg::KIND_DATA: begin
          q_op.register_select = 1'b1;
          q_op.tail            = clbs_pkg::TAIL_DATA;
        end
        clbs_pkg::KIND_INIT: begin
          q_op.op_kind = clbs_pkg::OP_POWERUP;
          q_op.last    = 1'b0;
          if (q_push) begin
            busy_next = 1'b1;
            step_next = 3'd1;
          end
        end
        clbs_pkg::KIND_CURSOR: q_op.byte_value = cursor_byte;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= 3'd0;
    end else begin
      busy <= busy_next;
      step <= step_next;
    end
  end

endmodule

FILE: rtl/core/clbs_queue.sv
// Short transfer queue between the front end and the bus driver.
module clbs_queue #(
  parameter int DEPTH = clbs_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  clbs_pkg::op_t push_op,
  output logic          q_full,
  output logic          q_empty,
  input  logic          pop,
  output clbs_pkg::op_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  clbs_pkg::op_t    slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign q_full  = (count == CNT_FULL);
  assign q_empty = (count == '0);
  assign do_push = push && !q_full;
  assign do_pop  = pop && !q_empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/clbs_back.sv
// Back end: expands queued transfers into pin states, one per cycle while pop keeps up.
`include "char_lcd_bus_sequencer_macros.svh"

module clbs_back (
  input  logic                 clk,
  input  logic                 rst,
  input  clbs_pkg::cfg_t       cfg,
  input  logic                 q_empty,
  input  clbs_pkg::op_t        op,
  output logic                 q_pop,
  output logic                 empty,
  input  logic                 pop,
  output clbs_pkg::pin_state_t pin_state
);

  logic [1:0]           phase, phase_next;
  logic [1:0]           last_phase;
  logic                 advance;
  logic                 out_valid;
  logic [7:0]           hi_bus, lo_bus;
  clbs_pkg::pin_state_t state_next;

  assign hi_bus  = clbs_pkg::place_nibble(op.byte_value[7:4], cfg.upper_nibble_lane);
  assign lo_bus  = clbs_pkg::place_nibble(op.byte_value[3:0], cfg.upper_nibble_lane);
  assign advance = !q_empty && (!out_valid || pop);
  assign empty   = !out_valid;

  always_comb begin
    if (op.op_kind == clbs_pkg::OP_POWERUP) begin
      last_phase = 2'd0;
    end else begin
      last_phase = cfg.four_bit_bus ? 2'd3 : 2'd1;
    end
    q_pop      = advance && (phase == last_phase);
    phase_next = phase;
    if (advance) begin
      phase_next = q_pop ? 2'd0 : phase + 2'd1;
    end

    state_next = '{bus_pins: op.byte_value, register_select: op.register_select,
                   enable_pin: 1'b1, hold_us: clbs_pkg::HOLD_STROBE,
                   last_state: 1'b0};
    if (op.op_kind == clbs_pkg::OP_POWERUP) begin
      state_next.bus_pins   = 8'h00;
      state_next.enable_pin = 1'b0;
      state_next.hold_us    = clbs_pkg::HOLD_POWERUP;
    end else if (cfg.four_bit_bus) begin
      unique case (phase)
        2'd0: state_next.bus_pins = hi_bus;
        2'd1: begin
          state_next.bus_pins   = hi_bus;
          state_next.enable_pin = 1'b0;
          state_next.hold_us    = clbs_pkg::HOLD_NIBBLE;
        end
        2'd2: state_next.bus_pins = lo_bus;
        default: begin
          state_next.bus_pins   = lo_bus;
          state_next.enable_pin = 1'b0;
          state_next.hold_us    = clbs_pkg::tail_hold(op.tail);
        end
      endcase
    end else if (phase != 2'd0) begin
      state_next.enable_pin = 1'b0;
      state_next.hold_us    = clbs_pkg::tail_hold(op.tail);
    end
    state_next.last_state = op.last && (phase == last_phase);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pin_state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (advance) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // a transfer in progress stays at the queue head until its last state
  `CLBS_ASSERT_NOW(a_phase_holds_op, phase != 2'd0, !q_empty, "transfer lost mid-expansion")
  `CLBS_ASSERT_NOW(a_nibble_phase_byte, phase > 2'd1, op.op_kind == clbs_pkg::OP_BYTE, "power-up op past first phase")
  `CLBS_ASSERT_NOW(a_strobe_not_last, out_valid && pin_state.enable_pin, !pin_state.last_state, "request ended on a strobe")
  `CLBS_ASSERT_NEXT(a_pop_clears_phase, q_pop, phase == 2'd0, "phase not reset after pop")

endmodule

FILE: rtl/core/char_lcd_bus_sequencer.sv
// Top level of the character LCD bus sequencer.
// Usage:
//   Requests enter on push/full with the request struct: command byte, data
//   byte, cursor move or the display init sequence. A request is taken at an
//   edge with push high and full low.
//   Pin states leave on empty/pop: while empty is low, pin_state holds the
//   oldest state (bus, RS, enable, hold time in us, last-state mark); pop
//   high takes it.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the bus width (index 0) and
//   the nibble lane (index 1); other indexes are ignored. Write only when idle.
// Timing:
//   The first pin state reaches pin_state via the transfer queue and the pin_state
//   register. While pop keeps up, the driver emits one pin state per cycle: a
//   byte is 4 pin states on a 4-bit bus and 2 on an 8-bit bus, the init request
//   25 or 9; the front end holds full high while it queues the init commands.
//   Requests keep being taken while states wait, until the transfer queue
//   fills; a stalled receiver holds the current state and backs up the queue.
// Reset: both channels empty, 4-bit bus on the upper lane selected.
module char_lcd_bus_sequencer #(
  parameter int LINE_LENGTH = clbs_pkg::LINE_LENGTH,
  parameter int QUEUE_DEPTH = clbs_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  clbs_pkg::request_t               request,
  output logic                             empty,
  input  logic                             pop,
  output clbs_pkg::pin_state_t             pin_state,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [clbs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic                             cfg_data
);

  clbs_pkg::cfg_t cfg;
  clbs_pkg::op_t  push_op, head_op;
  logic           q_push, q_pop, q_full, q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.four_bit_bus      <= 1'b1;
      cfg.upper_nibble_lane <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        clbs_pkg::REG_FOUR_BIT_BUS: cfg.four_bit_bus      <= cfg_data;
        clbs_pkg::REG_UPPER_LANE:   cfg.upper_nibble_lane <= cfg_data;
        default: ;
      endcase
    end
  end

  clbs_front #(
    .LINE_LENGTH(LINE_LENGTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .request (request),
    .cfg     (cfg),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_op    (push_op)
  );

  clbs_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_op (push_op),
    .q_full  (q_full),
    .q_empty (q_empty),
    .pop     (q_pop),
    .head    (head_op)
  );

  clbs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .op        (head_op),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .pin_state (pin_state)
  );

endmodule

FILE: bench/tb_char_lcd_bus_sequencer.sv
// Self-checking testbench of the character LCD bus sequencer: pin-state sequences vs prediction.
module tb_char_lcd_bus_sequencer;

  // Indexes past the register list; writes to them must change nothing.
  localparam logic [clbs_pkg::CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [clbs_pkg::CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

  localparam int CLK_HALF      = 10;
  localparam int SETTLE_CYCLES = 8;
  localparam int RUN_LIMIT     = 20_000_000;
  localparam int COLUMNS       = 40;

  localparam logic [clbs_pkg::HOLD_W-1:0] T_STROBE  = 15'd1;
  localparam logic [clbs_pkg::HOLD_W-1:0] T_NIBBLE  = 15'd100;
  localparam logic [clbs_pkg::HOLD_W-1:0] T_CMD     = 15'd10000;
  localparam logic [clbs_pkg::HOLD_W-1:0] T_DATA    = 15'd100;
  localparam logic [clbs_pkg::HOLD_W-1:0] T_CLEAR   = 15'd12000;
  localparam logic [clbs_pkg::HOLD_W-1:0] T_POWERUP = 15'd20000;

  localparam logic [7:0] ROW1_ADDR    = 8'h80;
  localparam logic [7:0] ROW2_ADDR    = 8'hC0;
  localparam logic [7:0] CMD_WAKE     = 8'h33;
  localparam logic [7:0] CMD_NIBBLE   = 8'h32;
  localparam logic [7:0] CMD_FUNC_4   = 8'h28;
  localparam logic [7:0] CMD_FUNC_8   = 8'h38;
  localparam logic [7:0] CMD_DISP_ON  = 8'h0E;
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_ENTRY    = 8'h06;

  logic                             clk;
  logic                             rst;
  logic                             push;
  logic                             full;
  clbs_pkg::request_t               request;
  logic                             empty;
  logic                             pop;
  clbs_pkg::pin_state_t             pin_state;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [clbs_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic                             cfg_data;

  // Predictor copy of the configuration.
  logic bus_four_bit;
  logic lane_upper;

  clbs_pkg::pin_state_t pending_states[$];
  int                   error_count;
  int                   send_idle_pct;
  int                   recv_idle_pct;

  char_lcd_bus_sequencer u_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .request   (request),
    .empty     (empty),
    .pop       (pop),
    .pin_state (pin_state),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    #RUN_LIMIT;
    $display("tb_char_lcd_bus_sequencer: errors");
    $finish;
  end

  // ---------------------------------------------------------------- prediction

  function automatic void queue_state(logic [7:0] bus, logic rs, logic en,
                                      logic [clbs_pkg::HOLD_W-1:0] hold);
    clbs_pkg::pin_state_t s;
    s.bus_pins        = bus;
    s.register_select = rs;
    s.enable_pin      = en;
    s.hold_us         = hold;
    s.last_state      = 1'b0;
    pending_states.push_back(s);
  endfunction

  function automatic logic [7:0] lane_nibble(logic [3:0] nib);
    return lane_upper ? {nib, 4'h0} : {4'h0, nib};
  endfunction

  function automatic void queue_byte(logic [7:0] b, logic rs,
                                     logic [clbs_pkg::HOLD_W-1:0] tail);
    if (bus_four_bit) begin
      queue_state(lane_nibble(b[7:4]), rs, 1'b1, T_STROBE);
      queue_state(lane_nibble(b[7:4]), rs, 1'b0, T_NIBBLE);
      queue_state(lane_nibble(b[3:0]), rs, 1'b1, T_STROBE);
      queue_state(lane_nibble(b[3:0]), rs, 1'b0, tail);
    end else begin
      queue_state(b, rs, 1'b1, T_STROBE);
      queue_state(b, rs, 1'b0, tail);
    end
  endfunction

  function automatic void expand_request(clbs_pkg::request_t r);
    clbs_pkg::pin_state_t s;
    logic [5:0] col;
    logic [7:0] base;
    case (r.kind)
      clbs_pkg::KIND_COMMAND: queue_byte(r.byte_value, 1'b0, T_CMD);
      clbs_pkg::KIND_DATA:    queue_byte(r.byte_value, 1'b1, T_DATA);
      clbs_pkg::KIND_INIT: begin
        queue_state(8'h00, 1'b0, 1'b0, T_POWERUP);
        if (bus_four_bit) begin
          queue_byte(CMD_WAKE, 1'b0, T_CMD);
          queue_byte(CMD_NIBBLE, 1'b0, T_CMD);
          queue_byte(CMD_FUNC_4, 1'b0, T_CMD);
        end else begin
          queue_byte(CMD_FUNC_8, 1'b0, T_CMD);
        end
        queue_byte(CMD_DISP_ON, 1'b0, T_CMD);
        queue_byte(CMD_CLEAR, 1'b0, T_CLEAR);
        queue_byte(CMD_ENTRY, 1'b0, T_CMD);
      end
      default: begin
        // saturate row and column into the display
        base = (r.cursor_row >= 2'd2) ? ROW2_ADDR : ROW1_ADDR;
        col  = r.cursor_column;
        if (col < 6'd1) col = 6'd1;
        if (col > COLUMNS) col = 6'(COLUMNS);
        queue_byte(base + {2'b00, col} - 8'd1, 1'b0, T_CMD);
      end
    endcase
    s = pending_states.pop_back();
    s.last_state = 1'b1;
    pending_states.push_back(s);
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_state(clbs_pkg::pin_state_t want, clbs_pkg::pin_state_t got);
    if (got.bus_pins !== want.bus_pins)
      report_mismatch($sformatf("bus_pins %h, want %h", got.bus_pins, want.bus_pins));
    if (got.register_select !== want.register_select)
      report_mismatch($sformatf("register_select %b, want %b",
                                got.register_select, want.register_select));
    if (got.enable_pin !== want.enable_pin)
      report_mismatch($sformatf("enable_pin %b, want %b", got.enable_pin, want.enable_pin));
    if (got.hold_us !== want.hold_us)
      report_mismatch($sformatf("hold_us %0d, want %0d", got.hold_us, want.hold_us));
    if (got.last_state !== want.last_state)
      report_mismatch($sformatf("last_state %b, want %b", got.last_state, want.last_state));
  endtask

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (pending_states.size() == 0)
        report_mismatch("pin state with nothing expected");
      else
        check_state(pending_states.pop_front(), pin_state);
    end
  end

  always @(negedge clk) begin
    if (rst)
      pop <= 1'b0;
    else
      pop <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------- stimulus

  function automatic clbs_pkg::request_t make_request(clbs_pkg::kind_t k, logic [7:0] b,
                                                      logic [1:0] row, logic [5:0] col);
    clbs_pkg::request_t r;
    r.kind          = k;
    r.byte_value    = b;
    r.cursor_row    = row;
    r.cursor_column = col;
    return r;
  endfunction

  function automatic clbs_pkg::request_t random_request();
    clbs_pkg::request_t r;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35)      r.kind = clbs_pkg::KIND_COMMAND;
    else if (pick < 70) r.kind = clbs_pkg::KIND_DATA;
    else if (pick < 78) r.kind = clbs_pkg::KIND_INIT;
    else                r.kind = clbs_pkg::KIND_CURSOR;
    r.byte_value    = 8'($urandom);
    r.cursor_row    = 2'($urandom);
    r.cursor_column = ($urandom_range(0, 3) == 0) ? 6'($urandom)
                                                  : 6'($urandom_range(1, COLUMNS));
    return r;
  endfunction

  // Called and returns at a falling edge; push stays high for a following item.
  task automatic send_request(clbs_pkg::request_t req);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push    <= 1'b1;
    request <= req;
    do @(posedge clk); while (full);
    expand_request(req);
    @(negedge clk);
  endtask

  task automatic send_random(int count);
    repeat (count) send_request(random_request());
  endtask

  task automatic stop_sending();
    push <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (pending_states.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [clbs_pkg::CFG_INDEX_W-1:0] idx, logic value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      clbs_pkg::REG_FOUR_BIT_BUS: bus_four_bit = value;
      clbs_pkg::REG_UPPER_LANE:   lane_upper   = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic reconfigure(logic four, logic upper);
    stop_sending();
    wait_drained();
    write_reg(clbs_pkg::REG_FOUR_BIT_BUS, four);
    write_reg(clbs_pkg::REG_UPPER_LANE, upper);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed_upper();
    send_idle_pct = 30;
    recv_idle_pct = 80;
    send_request(make_request(clbs_pkg::KIND_COMMAND, 8'h00, 2'($urandom), 6'($urandom)));
    send_request(make_request(clbs_pkg::KIND_COMMAND, 8'hFF, 2'($urandom), 6'($urandom)));
    send_request(make_request(clbs_pkg::KIND_DATA, 8'h00, 2'($urandom), 6'($urandom)));
    send_request(make_request(clbs_pkg::KIND_DATA, 8'hFF, 2'($urandom), 6'($urandom)));
    send_request(make_request(clbs_pkg::KIND_INIT, 8'($urandom), 2'($urandom),
                              6'($urandom)));
    send_request(make_request(clbs_pkg::KIND_CURSOR, 8'($urandom), 2'd1, 6'd1));
    send_request(make_request(clbs_pkg::KIND_CURSOR, 8'($urandom), 2'd2, 6'd40));
    // out-of-range row and column saturate
    send_request(make_request(clbs_pkg::KIND_CURSOR, 8'($urandom), 2'd0, 6'd0));
    send_request(make_request(clbs_pkg::KIND_CURSOR, 8'($urandom), 2'd3, 6'd63));
    send_request(make_request(clbs_pkg::KIND_CURSOR, 8'($urandom), 2'd1, 6'd41));
  endtask

  task automatic test_random_upper();
    send_random(60);
  endtask

  task automatic test_lower_lane();
    reconfigure(1'b1, 1'b0);
    send_idle_pct = 80;
    recv_idle_pct = 30;
    send_request(make_request(clbs_pkg::KIND_COMMAND, 8'hA5, 2'($urandom), 6'($urandom)));
    send_request(make_request(clbs_pkg::KIND_DATA, 8'h5A, 2'($urandom), 6'($urandom)));
    send_request(make_request(clbs_pkg::KIND_INIT, 8'($urandom), 2'($urandom),
                              6'($urandom)));
    send_request(make_request(clbs_pkg::KIND_CURSOR, 8'($urandom), 2'd2, 6'd17));
    send_random(50);
  endtask

  task automatic test_eight_bit();
    reconfigure(1'b0, 1'b1);
    send_request(make_request(clbs_pkg::KIND_INIT, 8'($urandom), 2'($urandom),
                              6'($urandom)));
    send_request(make_request(clbs_pkg::KIND_DATA, 8'hFF, 2'($urandom), 6'($urandom)));
    send_request(make_request(clbs_pkg::KIND_COMMAND, 8'h00, 2'($urandom), 6'($urandom)));
    send_request(make_request(clbs_pkg::KIND_CURSOR, 8'($urandom), 2'd2, 6'd40));
    send_random(30);
    // hold off until every pin state is out, then flip the unused lane bit
    stop_sending();
    wait_drained();
    write_reg(clbs_pkg::REG_UPPER_LANE, 1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(30);
  endtask

  task automatic test_ignored_index();
    reconfigure(1'b1, 1'b1);
    write_reg(REG_SPARE_A, 1'b0);
    write_reg(REG_SPARE_B, 1'b0);
    send_request(make_request(clbs_pkg::KIND_COMMAND, 8'h3C, 2'($urandom), 6'($urandom)));
    send_request(make_request(clbs_pkg::KIND_INIT, 8'($urandom), 2'($urandom),
                              6'($urandom)));
    send_random(30);
  endtask

  initial begin
    rst           = 1'b1;
    push          = 1'b0;
    pop           = 1'b0;
    request       = '0;
    cfg_valid     = 1'b0;
    cfg_index     = clbs_pkg::REG_FOUR_BIT_BUS;
    cfg_data      = 1'b0;
    bus_four_bit  = 1'b1;
    lane_upper    = 1'b1;
    error_count   = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_upper();
    test_random_upper();
    test_lower_lane();
    test_eight_bit();
    test_ignored_index();

    stop_sending();
    wait_drained();
    if (error_count == 0)
      $display("tb_char_lcd_bus_sequencer: clean");
    else
      $display("tb_char_lcd_bus_sequencer: errors");
    $finish;
  end

endmodule
